FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types, widths and the control store of the sort and search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  // fixed field widths
  localparam int ValW         = 32;
  localparam int StepsW       = 4;
  localparam int PosW         = 7;
  localparam int DepthDefault = 128;

  // step counter
  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;

  // step addresses of the program
  localparam step_t StIdle      = 4'd0;
  localparam step_t StDecode    = 4'd1;
  localparam step_t StLastChk   = 4'd2;
  localparam step_t StSortInit  = 4'd3;
  localparam step_t StOuter     = 4'd4;
  localparam step_t StLoadVi    = 4'd5;
  localparam step_t StInner     = 4'd6;
  localparam step_t StWriteBack = 4'd7;
  localparam step_t StSortDone  = 4'd8;
  localparam step_t StProbe     = 4'd9;
  localparam step_t StCompare   = 4'd10;
  localparam step_t StEmit      = 4'd11;
  localparam step_t StRetire    = 4'd12;

  // datapath action of one step
  typedef enum logic [3:0] {
    A_NOP,
    A_ACCEPT,
    A_SRCH_INIT,
    A_SORT_INIT,
    A_OUTER,
    A_LOAD_VI,
    A_INNER,
    A_WB_I,
    A_PROBE,
    A_UPDATE,
    A_EMIT
  } act_e;

  // jump condition of one step
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_ITEM,
    C_IS_SEARCH,
    C_NOT_LAST,
    C_CNT_LT2,
    C_INNER_MORE,
    C_OUTER_MORE,
    C_LO_GE_HI,
    C_MISS,
    C_OUT_BUSY
  } cond_e;

  // one control word
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  // control store: taken jump goes to target, otherwise to the next step
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: StIdle};
    case (pc)
      StIdle:      w = '{act: A_ACCEPT,    cond: C_NO_ITEM,    target: StIdle};
      StDecode:    w = '{act: A_SRCH_INIT, cond: C_IS_SEARCH,  target: StProbe};
      StLastChk:   w = '{act: A_NOP,       cond: C_NOT_LAST,   target: StIdle};
      StSortInit:  w = '{act: A_SORT_INIT, cond: C_CNT_LT2,    target: StIdle};
      StOuter:     w = '{act: A_OUTER,     cond: C_NEVER,      target: StIdle};
      StLoadVi:    w = '{act: A_LOAD_VI,   cond: C_NEVER,      target: StIdle};
      StInner:     w = '{act: A_INNER,     cond: C_INNER_MORE, target: StInner};
      StWriteBack: w = '{act: A_WB_I,      cond: C_OUTER_MORE, target: StOuter};
      StSortDone:  w = '{act: A_NOP,       cond: C_ALWAYS,     target: StIdle};
      StProbe:     w = '{act: A_PROBE,     cond: C_LO_GE_HI,   target: StEmit};
      StCompare:   w = '{act: A_UPDATE,    cond: C_MISS,       target: StProbe};
      StEmit:      w = '{act: A_EMIT,      cond: C_OUT_BUSY,   target: StEmit};
      StRetire:    w = '{act: A_NOP,       cond: C_ALWAYS,     target: StIdle};
      default:     w = '{act: A_NOP,       cond: C_ALWAYS,     target: StIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/sort_then_binary_search.sv
// ----------------------------------------------------------------------------
// sort_then_binary_search: value store, descending exchange sort, key search
// Load item: accept, decode and last check; a closing load of n > 1 values then runs
// the exchange sort, a closing load of one value adds the sort init step.
// Search of p probes: each probe is a probe step and a compare step; a miss adds a
// final probe step; result waits while the result register is stalled; the next
// item is taken after the retire step.
// Reset clears sequencer, counts and output valid; store holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module sort_then_binary_search
  import stbs_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     req_type_i,
  input  wire logic signed [ValW-1:0]   item_value_i,
  input  wire logic                     last_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          found_o,
  output logic             [StepsW-1:0] steps_o,
  output logic             [PosW-1:0]   position_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer
  step_t  pc_q, pc_d;
  uword_t uw;
  logic   jump;

  // control state
  logic [CW-1:0] lp_q, lp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  // datapath registers
  logic                   req_q, req_d;
  logic                   last_q, last_d;
  logic signed [ValW-1:0] key_q, key_d;
  logic signed [ValW-1:0] vi_q, vi_d;
  logic        [CW-1:0]   i_q, i_d;
  logic        [CW-1:0]   j_q, j_d;
  logic        [CW-1:0]   lo_q, lo_d;
  logic        [CW-1:0]   hi_q, hi_d;
  logic        [AW-1:0]   mid_q, mid_d;
  logic        [StepsW-1:0] steps_q, steps_d;
  logic                   found_q, found_d;
  logic        [AW-1:0]   pos_q, pos_d;
  logic                   res_found_q, res_found_d;
  logic        [StepsW-1:0] res_steps_q, res_steps_d;
  logic        [PosW-1:0] res_pos_q, res_pos_d;

  // store
  logic signed [ValW-1:0] mem [DEPTH];
  logic signed [ValW-1:0] rd_q;
  logic        [AW-1:0]   raddr;
  logic                   we;
  logic        [AW-1:0]   waddr;
  logic signed [ValW-1:0] wdata;

  // derived values
  logic          in_fire;
  logic          out_free;
  logic          room;
  logic [CW-1:0] lp_inc;
  logic [CW-1:0] j_inc;
  logic [CW:0]   i_inc2;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_a;
  logic [CW-1:0] mid_inc;
  logic          hit;
  logic          greater;
  logic [PosW-1:0] pos_ext;

  // control word of the current step
  assign uw = ucode_rom(pc_q);

  // handshakes
  assign in_stall_o = (uw.act != A_ACCEPT);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // address arithmetic and compares
  assign room    = (lp_q < CW'(DEPTH));
  assign lp_inc  = lp_q + CW'(1);
  assign j_inc   = j_q + CW'(1);
  assign i_inc2  = {1'b0, i_q} + (CW+1)'(2);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_a   = mid_sum[AW:1];
  assign mid_inc = CW'(mid_q) + CW'(1);
  assign hit     = (rd_q == key_q);
  assign greater = (rd_q > vi_q);

  // position field is the probe index cut or padded to its width
  if (AW >= PosW) begin : g_pos_cut
    assign pos_ext = pos_q[PosW-1:0];
  end else begin : g_pos_pad
    assign pos_ext = {{(PosW-AW){1'b0}}, pos_q};
  end

  // jump condition
  always_comb begin
    case (uw.cond)
      C_ALWAYS:     jump = 1'b1;
      C_NEVER:      jump = 1'b0;
      C_NO_ITEM:    jump = !in_fire;
      C_IS_SEARCH:  jump = req_q;
      C_NOT_LAST:   jump = !last_q;
      C_CNT_LT2:    jump = (cnt_q < CW'(2));
      C_INNER_MORE: jump = (j_inc < cnt_q);
      C_OUTER_MORE: jump = (i_inc2 < {1'b0, cnt_q});
      C_LO_GE_HI:   jump = (lo_q >= hi_q);
      C_MISS:       jump = !hit;
      C_OUT_BUSY:   jump = !out_free;
      default:      jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_d = jump ? uw.target : pc_q + step_t'(1);
  end

  // datapath actions
  always_comb begin
    lp_d        = lp_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    last_d      = last_q;
    key_d       = key_q;
    vi_d        = vi_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    steps_d     = steps_q;
    found_d     = found_q;
    pos_d       = pos_q;
    res_found_d = res_found_q;
    res_steps_d = res_steps_q;
    res_pos_d   = res_pos_q;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = vi_q;

    // output register drains independently of the program
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (uw.act)
      A_ACCEPT: begin
        if (in_fire) begin
          req_d  = req_type_i;
          last_d = last_i;
          key_d  = item_value_i;
          if (!req_type_i) begin
            if (room) begin
              we    = 1'b1;
              waddr = lp_q[AW-1:0];
              wdata = item_value_i;
              lp_d  = lp_inc;
            end
            if (last_i) begin
              cnt_d = room ? lp_inc : lp_q;
              lp_d  = '0;
            end
          end
        end
      end
      A_SRCH_INIT: begin
        lo_d    = '0;
        hi_d    = cnt_q;
        steps_d = '0;
        found_d = 1'b0;
        pos_d   = '0;
      end
      A_SORT_INIT: begin
        i_d = '0;
      end
      A_OUTER: begin
        j_d   = i_q + CW'(1);
        raddr = i_q[AW-1:0];
      end
      A_LOAD_VI: begin
        vi_d  = rd_q;
        raddr = j_q[AW-1:0];
      end
      A_INNER: begin
        // larger later value moves to slot i, the old one goes to slot j
        if (greater) begin
          we    = 1'b1;
          waddr = j_q[AW-1:0];
          wdata = vi_q;
          vi_d  = rd_q;
        end
        j_d   = j_inc;
        raddr = j_inc[AW-1:0];
      end
      A_WB_I: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = vi_q;
        i_d   = i_q + CW'(1);
      end
      A_PROBE: begin
        mid_d = mid_a;
        raddr = mid_a;
      end
      A_UPDATE: begin
        if (hit) begin
          found_d = 1'b1;
          pos_d   = mid_q;
        end else begin
          steps_d = steps_q + StepsW'(1);
          if (rd_q > key_q) begin
            lo_d = mid_inc;
          end else begin
            hi_d = CW'(mid_q);
          end
        end
      end
      A_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_found_d = found_q;
          res_steps_d = steps_q;
          res_pos_d   = found_q ? pos_ext : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StIdle;
      lp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      lp_q        <= lp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    last_q      <= last_d;
    key_q       <= key_d;
    vi_q        <= vi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    steps_q     <= steps_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
    res_found_q <= res_found_d;
    res_steps_q <= res_steps_d;
    res_pos_q   <= res_pos_d;
  end

  // value store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // result port
  assign out_valid_o = out_valid_q;
  assign found_o     = res_found_q;
  assign steps_o     = res_steps_q;
  assign position_o  = res_pos_q;

endmodule

`default_nettype wire

FILE: src/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the sort and search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stbs_checker
  import stbs_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     req_type_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic                     found_o,
  input wire logic        [StepsW-1:0] steps_o,
  input wire logic        [PosW-1:0]   position_o
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o,
               "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
               $stable({found_o, steps_o, position_o}), "result changed while stalled")

  // a miss reports position zero
  `ASSERT_NOW(a_miss_pos, clk_i, rst_ni, out_valid_o && !found_o, position_o == '0,
              "miss with nonzero position")

  // a search item keeps the block busy in the next cycle
  `ASSERT_NEXT(a_search_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && req_type_i,
               in_stall_o, "item taken while a search is running")

endmodule

bind sort_then_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sort_then_binary_search
// Sends load sets and key searches in random bursts to a receiver that stalls
// on its own pattern. A local mirror of the value store sorts each closed set
// and runs the binary search. Every result is compared in order with it or with
// the result a typed directed row carries. A directed table goes first, then random
// load sets, each followed by searches.
module testbench;
  import stbs_pkg::*;

  localparam int   Depth        = DepthDefault;
  localparam int   RandomItems  = 1050;
  localparam int   CycleLimit   = 1_000_000;
  localparam int   SettleCycles = 50;
  localparam int   DirectedRows = 25;
  localparam logic ReqLoad      = 1'b0;
  localparam logic ReqSearch    = 1'b1;

  typedef logic signed [ValW-1:0] value_t;

  typedef struct packed {
    logic              found;
    logic [StepsW-1:0] steps;
    logic [PosW-1:0]   position;
  } search_res_t;

  typedef struct packed {
    logic        req_type;
    value_t      value;
    logic        last;
    logic        typed;
    search_res_t res;
  } stim_row_t;

  // how load values are drawn for one set
  typedef enum int {MixFull, MixNarrow, MixEdge, MixBlend} val_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  value_t            item_value_i;
  logic              last_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              found_o;
  logic [StepsW-1:0] steps_o;
  logic [PosW-1:0]   position_o;

  // mirror of the block state
  value_t      sorted_store [Depth];
  int          set_size;
  int          fill_ptr;
  search_res_t pending_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int stall_hold  = 0;

  sort_then_binary_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .steps_o      (steps_o),
    .position_o   (position_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // store one value; a closing item sorts the set in descending order
  function automatic void load_value(value_t v, logic closing);
    value_t t;
    if (fill_ptr < Depth) begin
      sorted_store[fill_ptr] = v;
      fill_ptr++;
    end
    if (closing) begin
      set_size = fill_ptr;
      fill_ptr = 0;
      for (int i = 0; i + 1 < set_size; i++) begin
        for (int j = i + 1; j < set_size; j++) begin
          if (sorted_store[j] > sorted_store[i]) begin
            t = sorted_store[i];
            sorted_store[i] = sorted_store[j];
            sorted_store[j] = t;
          end
        end
      end
    end
  endfunction

  // binary search over the closed set, counting probes that miss
  function automatic search_res_t search_key(value_t key);
    search_res_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    lo = 0;
    hi = set_size;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (sorted_store[mid] == key) begin
        r.found = 1'b1;
        r.position = mid[PosW-1:0];
        break;
      end
      r.steps = r.steps + 1'b1;
      if (sorted_store[mid] > key) lo = mid + 1;
      else hi = mid;
    end
    return r;
  endfunction

  function automatic value_t pick_value(val_mix_e mix);
    value_t v;
    case (mix)
      MixFull:   v = value_t'($urandom);
      MixNarrow: v = value_t'($urandom_range(0, 15)) - value_t'(8);
      MixEdge: begin
        if ($urandom_range(0, 1) == 1) v = value_t'(32'h7fff_ffff - $urandom_range(0, 3));
        else v = value_t'(32'h8000_0000 + $urandom_range(0, 3));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) v = value_t'(32'h8000_0000);
        else v = value_t'($urandom);
      end
    endcase
    return v;
  endfunction

  // mostly keys held in the set, some next to them, some anywhere
  function automatic value_t pick_key();
    value_t k;
    int sel;
    sel = $urandom_range(0, 9);
    if (set_size > 0 && sel < 6) begin
      k = sorted_store[$urandom_range(0, set_size - 1)];
      if (sel == 5) k = ($urandom_range(0, 1) == 1) ? k + 1 : k - 1;
    end else if (sel < 8) begin
      k = value_t'($urandom);
    end else begin
      k = (sel == 8) ? value_t'(32'h7fff_ffff) : value_t'(32'h8000_0000);
    end
    return k;
  endfunction

  // hand over one item, idling between bursts; the mirror updates on accept
  task automatic send_item(logic req, value_t v, logic closing, logic typed,
                           search_res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    item_value_i <= v;
    last_i       <= closing;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (req == ReqSearch) pending_q.push_back(typed ? typed_res : search_key(v));
    else load_value(v, closing);
    @(negedge clk_i);
  endtask

  // hold off the sender until every search result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver stall: a new stall rate now and then, zero among them
  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        3:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_hold = $urandom_range(20, 150);
    end else begin
      stall_hold--;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare each delivered result with the oldest expected one
  always @(posedge clk_i) begin
    search_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected: found %0d steps %0d position %0d",
                 $time, found_o, steps_o, position_o);
        error_count++;
      end else begin
        exp_res = pending_q.pop_front();
        if (found_o !== exp_res.found) begin
          $display("%0t: found expected %0d got %0d", $time, exp_res.found, found_o);
          error_count++;
        end
        if (steps_o !== exp_res.steps) begin
          $display("%0t: steps expected %0d got %0d", $time, exp_res.steps, steps_o);
          error_count++;
        end
        if (position_o !== exp_res.position) begin
          $display("%0t: position expected %0d got %0d", $time, exp_res.position,
                   position_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed [DirectedRows];
    int        rand_items;
    int        rounds;
    int        big_sets;
    int        set_len;
    int        n_search;
    val_mix_e  mix;
    logic      closing;

    // rows marked typed carry their result; the rest go through the mirror
    directed = '{
      // empty set after reset, last on a search is ignored
      '{ReqSearch, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 4'd0, 7'd0}},
      '{ReqSearch, 32'h7fff_ffff, 1'b0, 1'b1, '{1'b0, 4'd0, 7'd0}},
      '{ReqSearch, 32'h8000_0000, 1'b1, 1'b1, '{1'b0, 4'd0, 7'd0}},
      // search while loading still sees the empty set
      '{ReqLoad,   32'h0000_0005, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0005, 1'b0, 1'b1, '{1'b0, 4'd0, 7'd0}},
      // extremes and a repeated value
      '{ReqLoad,   32'h8000_0000, 1'b0, 1'b0, '0},
      '{ReqLoad,   32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{ReqLoad,   32'h0000_0005, 1'b0, 1'b0, '0},
      '{ReqLoad,   32'h0000_0000, 1'b0, 1'b0, '0},
      '{ReqLoad,   32'hffff_ffff, 1'b1, 1'b0, '0},
      '{ReqSearch, 32'h7fff_ffff, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0005, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0003, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'hffff_ffff, 1'b0, 1'b0, '0},
      // new set of one element overwrites from slot zero
      '{ReqLoad,   32'h0000_0007, 1'b1, 1'b0, '0},
      '{ReqSearch, 32'h0000_0007, 1'b0, 1'b1, '{1'b1, 4'd0, 7'd0}},
      '{ReqSearch, 32'h0000_0008, 1'b1, 1'b0, '0},
      // open load changes the store under the closed set
      '{ReqLoad,   32'h0000_0064, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0007, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'h0000_0064, 1'b0, 1'b0, '0},
      '{ReqLoad,   32'h0000_0001, 1'b1, 1'b0, '0},
      '{ReqSearch, 32'h0000_0001, 1'b0, 1'b0, '0},
      '{ReqSearch, 32'hffff_fffb, 1'b0, 1'b0, '0}
    };

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = ReqLoad;
    item_value_i = '0;
    last_i       = 1'b0;
    set_size     = 0;
    fill_ptr     = 0;
    for (int i = 0; i < Depth; i++) sorted_store[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirectedRows; r++) begin
      send_item(directed[r].req_type, directed[r].value, directed[r].last,
                directed[r].typed, directed[r].res);
    end
    wait_drained();

    // random load sets, each followed by searches
    rand_items = 0;
    rounds     = 0;
    big_sets   = 0;
    while (rand_items < RandomItems) begin
      rounds++;
      mix = val_mix_e'($urandom_range(0, 3));
      // a few sets around the store size, one filling it and dropping the last
      if (rounds % 16 == 3 && big_sets < 3) begin
        big_sets++;
        set_len = Depth - 2 + big_sets;
      end else begin
        set_len = $urandom_range(1, 16);
      end
      // load sequence with stray searches, now and then left open
      for (int k = 0; k < set_len; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(ReqSearch, pick_key(), 1'($urandom_range(0, 1)), 1'b0, '0);
          rand_items++;
        end
        closing = (k == set_len - 1) && ($urandom_range(0, 9) != 0);
        send_item(ReqLoad, pick_value(mix), closing, 1'b0, '0);
        rand_items++;
      end
      n_search = $urandom_range(2, 12);
      for (int k = 0; k < n_search; k++) begin
        send_item(ReqSearch, pick_key(), 1'($urandom_range(0, 1)), 1'b0, '0);
        rand_items++;
      end
      if (rounds % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
